FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the parity encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rsenc_pkg.sv
// Constants, types and GF(256) arithmetic for the parity encoder.
`timescale 1ns / 1ps
`default_nettype none

package rsenc_pkg;

    localparam int MAX_PARITY = 32;
    localparam int IDX_W = $clog2(MAX_PARITY);
    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam int CFG_W = 6;
    localparam int BYTE_W = 8;
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [CFG_W-1:0] RESET_PARITY = 6'd10;

    typedef logic [BYTE_W-1:0] gf_t;
    typedef logic [MAX_PARITY-1:0][BYTE_W-1:0] byte_vec_t;

    typedef struct packed {
        logic init;
        logic build;
        logic absorb;
        logic clear;
    } cell_ctrl_t;

    function automatic gf_t gf_xtime(input gf_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    function automatic gf_t gf_mul(input gf_t a, input gf_t b);
        gf_t acc;
        gf_t x;
        acc = '0;
        x = a;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

    // Clamps the register value to the supported range of parity counts.
    function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] pc);
        if (pc == '0)
        begin
            return CNT_W'(1);
        end
        else if (int'(pc) > MAX_PARITY)
        begin
            return CNT_W'(MAX_PARITY);
        end
        else
        begin
            return CNT_W'(pc);
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rsenc_if.sv
// Valid/ready channel interfaces for message bytes and parity bytes.
`timescale 1ns / 1ps
`default_nettype none

interface rsenc_msg_if
    import rsenc_pkg::*;
    ;
    logic  valid;
    logic  ready;
    gf_t   data_byte;
    logic  last_data;

    modport source (output valid, output data_byte, output last_data, input ready);
    modport sink (input valid, input data_byte, input last_data, output ready);
endinterface

interface rsenc_par_if
    import rsenc_pkg::*;
    ;
    logic  valid;
    logic  ready;
    gf_t   parity_byte;
    logic  last_parity;

    modport source (output valid, output parity_byte, output last_parity, input ready);
    modport sink (input valid, input parity_byte, input last_parity, output ready);
endinterface

`default_nettype wire

FILE: rtl/rsenc_cell.sv
// One tap of the remainder register with its generator coefficient.
`timescale 1ns / 1ps
`default_nettype none

module rsenc_cell
    import rsenc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       seed,
    input  wire gf_t        fb,
    input  wire gf_t        root,
    input  wire gf_t        prev_rem,
    input  wire gf_t        prev_gen,
    output gf_t             rem,
    output gf_t             gen,
    output gf_t             rem_calc
);

    gf_t rem_reg;
    gf_t rem_next;
    gf_t gen_reg;
    gf_t gen_next;
    gf_t prod;

    // The multiplier is shared between absorbing a byte and building the generator.
    assign prod = gf_mul(ctrl.build ? root : fb, gen_reg);
    assign rem_calc = prev_rem ^ prod;

    always_comb
    begin
        rem_next = rem_reg;
        if (ctrl.clear)
        begin
            rem_next = '0;
        end
        else if (ctrl.absorb)
        begin
            rem_next = rem_calc;
        end
    end

    always_comb
    begin
        gen_next = gen_reg;
        if (ctrl.init)
        begin
            gen_next = {7'b0, seed};
        end
        else if (ctrl.build)
        begin
            gen_next = prev_gen ^ prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            gen_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            gen_reg <= gen_next;
        end
    end

    assign rem = rem_reg;
    assign gen = gen_reg;

endmodule

`default_nettype wire

FILE: rtl/rsenc_outbuf.sv
// Parity shift register that drains one finished remainder onto the output channel.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsenc_outbuf
    import rsenc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire byte_vec_t         load_data,
    input  wire logic [CNT_W-1:0]  n,
    output logic                   free,
    rsenc_par_if.source            parity
);

    byte_vec_t         par_reg;
    byte_vec_t         par_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              fire;
    logic [IDX_W-1:0]  top_idx;

    assign fire = parity.valid & parity.ready;
    assign free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && fire);
    assign top_idx = IDX_W'(n - CNT_W'(1));

    always_comb
    begin
        par_next = par_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            par_next = load_data;
            cnt_next = n;
        end
        else if (fire)
        begin
            par_next = {par_reg[MAX_PARITY-2:0], 8'h00};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg <= par_next;
    end

    assign parity.valid = (cnt_reg != '0);
    assign parity.parity_byte = par_reg[top_idx];
    assign parity.last_parity = (cnt_reg == CNT_W'(1));

    `RSE_ASSERT_IMPL(a_load_when_free, load, free, "parity buffer loaded while still draining")
    `RSE_ASSERT(a_cnt_range, int'(cnt_reg) <= MAX_PARITY, "parity count out of range")

endmodule

`default_nettype wire

FILE: rtl/reed_solomon_parity_encoder_core.sv
// Top level of the systematic Reed-Solomon parity encoder over GF(256).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Message bytes enter highest degree first at one beat per cycle; each beat is
// absorbed by a row of cells that all do one GF(256) multiply-accumulate in that
// cycle. When the beat marked last is taken, the n parity bytes move into an
// output shift register as soon as it is free and leave at one beat per cycle while
// the output is ready, highest degree first, while the next message already streams
// in. Outside a rebuild the input stalls only when a message ends before the
// previous parity has fully drained. After reset and after every write of the parity
// count the cells rebuild the generator in ST_INIT and ST_BUILD, accepting no message beat.
module reed_solomon_parity_encoder_core
    import rsenc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    rsenc_msg_if.sink              message,
    rsenc_par_if.source            parity
);

    typedef enum logic [2:0] {
        ST_INIT  = 3'b001,
        ST_BUILD = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CFG_W-1:0]  pc_reg;
    logic [CNT_W-1:0]  build_cnt_reg;
    logic [CNT_W-1:0]  build_cnt_next;
    gf_t               root_reg;
    gf_t               root_next;
    logic              held_reg;
    logic              held_next;

    logic [CNT_W-1:0]  n;
    logic [IDX_W-1:0]  top_idx;
    gf_t               fb;
    logic              in_fire;
    logic              free;
    logic              load;
    byte_vec_t         rem_vec;
    byte_vec_t         gen_vec;
    byte_vec_t         calc_vec;
    byte_vec_t         load_data;
    cell_ctrl_t        ctrl;

    assign n = active_count(pc_reg);
    assign top_idx = IDX_W'(n - CNT_W'(1));
    assign fb = message.data_byte ^ rem_vec[top_idx];

    assign message.ready = (state_reg == ST_RUN) && !held_reg;
    assign in_fire = message.valid & message.ready;

    assign load = (in_fire && message.last_data && free) || (held_reg && free);
    assign load_data = held_reg ? rem_vec : calc_vec;

    assign ctrl.init = (state_reg == ST_INIT);
    assign ctrl.build = (state_reg == ST_BUILD);
    assign ctrl.absorb = in_fire;
    assign ctrl.clear = cfg_we || load || (state_reg == ST_INIT);

    for (genvar k = 0; k < MAX_PARITY; k++)
    begin : g_cell
        rsenc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .seed     (k == 0),
            .fb       (fb),
            .root     (root_reg),
            .prev_rem ((k == 0) ? gf_t'(0) : rem_vec[(k == 0) ? 0 : k - 1]),
            .prev_gen ((k == 0) ? gf_t'(0) : gen_vec[(k == 0) ? 0 : k - 1]),
            .rem      (rem_vec[k]),
            .gen      (gen_vec[k]),
            .rem_calc (calc_vec[k])
        );
    end

    rsenc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (load_data),
        .n         (n),
        .free      (free),
        .parity    (parity)
    );

    always_comb
    begin
        state_next = state_reg;
        build_cnt_next = build_cnt_reg;
        root_next = root_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                state_next = ST_BUILD;
                build_cnt_next = n;
                root_next = 8'h01;
            end
            ST_BUILD:
            begin
                build_cnt_next = build_cnt_reg - CNT_W'(1);
                root_next = gf_xtime(root_reg);
                if (build_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_INIT;
        end
    end

    always_comb
    begin
        held_next = held_reg;
        if (cfg_we)
        begin
            held_next = 1'b0;
        end
        else if (in_fire && message.last_data && !free)
        begin
            held_next = 1'b1;
        end
        else if (held_reg && free)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pc_reg <= RESET_PARITY;
            build_cnt_reg <= '0;
            root_reg <= 8'h01;
            held_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_cnt_reg <= build_cnt_next;
            root_reg <= root_next;
            held_reg <= held_next;
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
        end
    end

    `RSE_ASSERT_IMPL(a_no_beat_in_build, state_reg != ST_RUN, !message.ready, "beat in build")
    `RSE_ASSERT_NEXT(a_cfg_restarts, cfg_we, state_reg == ST_INIT, "no rebuild after write")
    `RSE_ASSERT_IMPL(a_held_only_when_busy, held_reg, parity.valid, "held while idle")

endmodule

`default_nettype wire
